### sv/abra_pkg.sv
// Package for the aligned bitmap range allocator: sizes, codes and helpers.
// No dependencies.
`default_nettype none
package abra_pkg;
  localparam int unsigned Units      = 1024;
  localparam int unsigned UnitFrames = 512;
  localparam int unsigned WordBits   = 32;
  localparam int unsigned Words      = Units / WordBits;
  localparam int unsigned FrameW     = 36;
  localparam int unsigned CountW     = 11;
  localparam int unsigned UnitW      = $clog2(Units);
  localparam int unsigned WordIdxW   = $clog2(Words);
  localparam int unsigned BitIdxW    = $clog2(WordBits);
  localparam int unsigned UfShift    = $clog2(UnitFrames);

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StNoSpace = 2'd2;

  localparam logic FuncAlloc = 1'b0;
  localparam logic FuncFree  = 1'b1;

  localparam logic RegBaseFrame  = 1'b0;
  localparam logic RegUnitsInUse = 1'b1;
endpackage
`default_nettype wire

### sv/abra_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module abra_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### sv/aligned_bitmap_range_allocator_unit.sv
// Aligned bitmap range allocator top level: sequencer around a bitmap RAM.
// Depends on abra_pkg and abra_ram.
//
// Usage: one input transaction (func, unit_count, free_frame) gives one result
// transaction (status, granted_frame). The used bitmap lies in a RAM of 32
// words of 32 bits. After reset a clearing pass zeroes the RAM; no input is
// taken during it, configuration writes are taken as ever.
// An allocate scans the words from the word of the first aligned start, word
// by word (read, then check every candidate that ends in the word, carrying
// the free streak from earlier words). A found run is then marked word by word
// (read, then write back); if none is found, the scan ends with no space. A
// free reads and clears each word it touches the same way. Invalid items,
// oversized requests and zero frees go straight to the result.
// The input is ready again in the cycle after the result goes out, so a new
// item is taken only once the last one's result has gone out. One output
// register holds a result until taken; the next item is processed meanwhile,
// and its result waits in the sequencer, which stalls the input side while
// the receiver stalls.
`default_nettype none
module aligned_bitmap_range_allocator_unit import abra_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,  // unit_count[10:0], free_frame[46:11], pad
  input  wire logic        s_axis_tuser_i,  // func
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [39:0]      m_axis_tdata_o,  // status[1:0], granted_frame[37:2], pad
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_addr_i,
  input  wire logic [35:0] cfg_wdata_i
);
  localparam logic [2:0] SClr = 3'd0, SIdle = 3'd1, SRd = 3'd2, SChk = 3'd3,
                         SUpd = 3'd4, SOut = 3'd5;

  logic [2:0] state_q, state_d;
  logic [FrameW-1:0] base_q;
  logic [CountW-1:0] uiu_q;

  logic              func_q;
  logic [CountW-1:0] cnt_q;
  logic [UnitW:0]    cur_q, cur_d;   // current unit index, word aligned
  logic [UnitW:0]    run_q, run_d;   // first unit of span to mark or free
  logic [UnitW:0]    end_q, end_d;   // exclusive end of that span
  logic [UnitW:0]    size_q;         // clamped units_in_use
  logic [UnitW:0]    off_q;          // first aligned start index
  logic [UnitW:0]    streak_q, streak_d;  // all units from here to cur word are free
  logic              mark_q, mark_d;  // update pass sets bits instead of clearing
  logic [1:0]        st_q, st_d;
  logic [FrameW-1:0] gf_q, gf_d;

  // Output register
  logic              out_vld_q;
  logic [1:0]        out_st_q;
  logic [FrameW-1:0] out_gf_q;
  logic              out_load;

  // RAM port
  logic                ram_we;
  logic [WordIdxW-1:0] ram_wa, ram_ra;
  logic [WordBits-1:0] ram_wd, ram_rd;

  abra_ram #(.Width(WordBits), .Depth(Words)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      uiu_q  <= '0;
    end else if (cfg_we_i) begin
      if (cfg_addr_i == RegBaseFrame) base_q <= cfg_wdata_i;
      else uiu_q <= cfg_wdata_i[CountW-1:0];
    end
  end

  // Decode input
  logic [CountW-1:0] in_cnt;
  logic [FrameW-1:0] in_frame;
  logic              in_pow2;
  logic [UnitW:0]    in_size;
  logic [UnitW:0]    in_off;
  logic [FrameW-1:0] in_rel;
  logic [FrameW+CountW:0] in_end, in_lim;
  logic              in_bad_free;
  assign in_cnt   = s_axis_tdata_i[10:0];
  assign in_frame = s_axis_tdata_i[46:11];
  assign in_pow2  = (in_cnt != '0) && ((in_cnt & (in_cnt - 1'b1)) == '0);
  assign in_size  = (uiu_q > CountW'(Units)) ? (UnitW+1)'(Units) : uiu_q[UnitW:0];
  // off = (base/UF) mod count; first start = (count-off) mod count
  logic [UnitW:0] bu;
  assign bu     = base_q[UfShift +: (UnitW+1)] & (in_cnt[UnitW:0] - 1'b1);
  assign in_off = (in_cnt[UnitW:0] - bu) & (in_cnt[UnitW:0] - 1'b1);
  assign in_rel = in_frame - base_q;
  assign in_end = (FrameW+CountW+1)'(in_frame) + ((FrameW+CountW+1)'(in_cnt) << UfShift);
  assign in_lim = (FrameW+CountW+1)'(base_q) + ((FrameW+CountW+1)'(in_size) << UfShift);
  assign in_bad_free = (in_frame < base_q) || (in_end > in_lim);

  assign s_axis_tready_o = (state_q == SIdle);
  wire in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // Word-local helpers
  logic [WordIdxW-1:0] cur_w;
  logic [UnitW:0]      wbase;
  logic [UnitW:0]      nxt_w;
  assign cur_w = cur_q[BitIdxW +: WordIdxW];
  assign wbase = {cur_q[UnitW:BitIdxW], BitIdxW'(0)};
  assign nxt_w = wbase + (UnitW+1)'(WordBits);

  // Lowest aligned free run that ends in the current word
  logic                afound;
  logic [BitIdxW-1:0]  apos;
  logic [UnitW:0]      p_u, s_u;
  logic [WordBits-1:0] upto_m, from_m;
  logic                hit;
  always_comb begin
    afound = 1'b0;
    apos   = '0;
    p_u    = '0;
    s_u    = '0;
    upto_m = '0;
    from_m = '0;
    hit    = 1'b0;
    for (int b = WordBits - 1; b >= 0; b--) begin
      p_u    = wbase + (UnitW+1)'(b);
      s_u    = p_u + 1'b1 - cnt_q[UnitW:0];
      upto_m = {WordBits{1'b1}} >> (WordBits - 1 - b);
      from_m = ~((WordBits'(1) << s_u[BitIdxW-1:0]) - 1'b1);
      if (s_u >= wbase) hit = (ram_rd & upto_m & from_m) == '0;
      else hit = (streak_q <= s_u) && ((ram_rd & upto_m) == '0);
      if ((p_u + 1'b1 >= cnt_q[UnitW:0]) && (p_u < size_q) && (s_u >= off_q)
          && (((s_u - off_q) & (cnt_q[UnitW:0] - 1'b1)) == '0) && hit) begin
        afound = 1'b1;
        apos   = BitIdxW'(b);
      end
    end
  end

  // Highest used bit of the current word
  logic [BitIdxW-1:0] hi;
  always_comb begin
    hi = '0;
    for (int b = 0; b < WordBits; b++) begin
      if (ram_rd[b]) hi = BitIdxW'(b);
    end
  end

  // Start of the found run
  logic [UnitW:0] sf;
  assign sf = wbase + (UnitW+1)'(apos) + 1'b1 - cnt_q[UnitW:0];

  // Update mask of current word for span [run_q, end_q)
  logic [WordBits-1:0] fmask;
  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      fmask[b] = ((wbase + (UnitW+1)'(b)) >= run_q) && ((wbase + (UnitW+1)'(b)) < end_q);
    end
  end

  assign out_load = (state_q == SOut) && (!out_vld_q || m_axis_tready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cur_d = cur_q; run_d = run_q; end_d = end_q; mark_d = mark_q;
    streak_d = streak_q;
    st_d = st_q; gf_d = gf_q;
    ram_we = 1'b0; ram_wa = cur_w; ram_wd = '0; ram_ra = cur_w;
    case (state_q)
      SClr: begin
        ram_we = 1'b1;
        cur_d  = nxt_w;
        if (cur_w == WordIdxW'(Words - 1)) begin
          state_d = SIdle;
          cur_d   = '0;
        end
      end
      SIdle: ;
      SRd: state_d = (func_q == FuncFree || mark_q) ? SUpd : SChk;
      SChk: begin
        if (afound) begin
          st_d    = StOk;
          gf_d    = base_q + (FrameW'(sf) << UfShift);
          run_d   = sf;
          end_d   = sf + cnt_q[UnitW:0];
          cur_d   = sf & ~(UnitW+1)'(WordBits - 1);
          mark_d  = 1'b1;
          state_d = SRd;
        end else if (nxt_w >= size_q || cur_w == WordIdxW'(Words - 1)) begin
          st_d = StNoSpace; state_d = SOut;
        end else begin
          if (ram_rd != '0) streak_d = wbase + (UnitW+1)'(hi) + 1'b1;
          cur_d = nxt_w; state_d = SRd;
        end
      end
      SUpd: begin
        ram_we = 1'b1;
        ram_wd = mark_q ? (ram_rd | fmask) : (ram_rd & ~fmask);
        if (nxt_w >= end_q || cur_w == WordIdxW'(Words - 1)) state_d = SOut;
        else begin
          cur_d = nxt_w; state_d = SRd;
        end
      end
      SOut: if (out_load) state_d = SIdle;
      default: state_d = SIdle;
    endcase
    if (in_acc) begin
      st_d = StOk; gf_d = '0; mark_d = 1'b0;
      if (s_axis_tuser_i == FuncAlloc) begin
        if (!in_pow2) begin
          st_d = StInvalid; state_d = SOut;
        end else if (in_cnt[UnitW:0] > in_size) begin
          st_d = StNoSpace; state_d = SOut;
        end else begin
          cur_d    = in_off & ~(UnitW+1)'(WordBits - 1);
          streak_d = in_off & ~(UnitW+1)'(WordBits - 1);
          state_d  = SRd;
        end
      end else begin
        if (in_bad_free) begin
          st_d = StInvalid; state_d = SOut;
        end else if (in_cnt == '0) begin
          state_d = SOut;
        end else begin
          run_d = in_rel[UfShift +: (UnitW+1)];
          end_d = in_rel[UfShift +: (UnitW+1)] + in_cnt[UnitW:0];
          cur_d = in_rel[UfShift +: (UnitW+1)] & ~(UnitW+1)'(WordBits - 1);
          state_d = SRd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClr;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    run_q <= run_d; end_q <= end_d; mark_q <= mark_d;
    streak_q <= streak_d;
    st_q <= st_d; gf_q <= gf_d;
    if (in_acc) begin
      func_q <= s_axis_tuser_i;
      cnt_q  <= in_cnt;
      size_q <= in_size;
      off_q  <= in_off;
    end
  end

  // Hold one result until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_st_q <= st_q;
      out_gf_q <= gf_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {2'b00, out_gf_q, out_st_q};

  // Assertions
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SIdle) |-> !s_axis_tready_o) else $error("ready while busy");
  a_ok_alloc_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_st_q != StOk) |-> (out_gf_q == '0)) else $error("frame on error");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle || state_q == SOut) |-> !ram_we) else $error("stray write");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("result changed while stalled");
endmodule
`default_nettype wire
